[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SKRC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define SKRC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[hw/rtl/skrc_pkg.sv]
// Package for the soft-knee range compressor: types, constants, root table function
package skrc_pkg;

	localparam int SAMPLE_BITS_DEF = 16;

	localparam logic [2:0] REG_THRESHOLD = 3'd0;
	localparam logic [2:0] REG_RATIO     = 3'd1;
	localparam logic [2:0] REG_ATTACK    = 3'd2;
	localparam logic [2:0] REG_RELEASE   = 3'd3;
	localparam logic [2:0] REG_KNEE      = 3'd4;

	localparam logic signed [15:0] THRESHOLD_RST = -16'sd5120;
	localparam logic [12:0] RATIO_RST   = 13'd1024;
	localparam logic [16:0] ATTACK_RST  = 17'd66;
	localparam logic [16:0] RELEASE_RST = 17'd3277;
	localparam logic [12:0] KNEE_RST    = 13'd1280;

	localparam logic signed [15:0] LEVEL_FLOOR = -16'sd25600;
	localparam logic [18:0] DB_PER_OCT_Q16 = 19'd394566;
	localparam logic [21:0] LOG2_10_OVER_20_Q24 = 22'd2786635;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_NORM,
		ST_LOG,
		ST_LEVEL,
		ST_PREP,
		ST_DIV,
		ST_ENV,
		ST_GAIN,
		ST_EXP,
		ST_MAG,
		ST_OUT
	} state_t;

	// 2^(2^-k) in Q1.30, by repeated truncated square roots
	function automatic logic [31:0] exp_root(input int k);
		logic [63:0] r;
		logic [63:0] v;
		logic [63:0] q;
		logic [63:0] b;
		r = 64'd1 << 31;
		for (int j = 1; j <= k; j++) begin
			v = r << 30;
			q = '0;
			b = 64'd1 << 62;
			for (int i = 0; i < 32; i++) begin
				if (v >= q + b) begin
					v = v - (q + b);
					q = (q >> 1) + b;
				end else begin
					q = q >> 1;
				end
				b = b >> 2;
			end
			r = q;
		end
		return r[31:0];
	endfunction

endpackage

[hw/rtl/soft_knee_range_compressor.sv]
// Soft-knee range compressor top level
// One sample in, one gain-adjusted sample out, worked on one at a time by a single
// shared 33x33 multiplier and a restoring divider under a small sequencer. The steps
// are the one-bit-a-cycle normalise (its length set by the sample's magnitude), the log2
// squaring loop, the level step, the divider, the exp2 root product and the remaining
// single steps. A sample of zero skips normalise and log. The input is accepted only
// when the sequencer is idle, in the cycle after it hands its result on; a finished
// result waits in the output register without blocking it, and the sequencer holds in
// its last step only while that register is still full.
module soft_knee_range_compressor #(
	parameter int SAMPLE_BITS = skrc_pkg::SAMPLE_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,  // in_sample
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,  // out_sample
	output logic m_axis_tuser,                              // clipped
	input  logic cfg_we,
	input  logic [2:0] cfg_addr,
	input  logic [16:0] cfg_wdata
);

`include "assert_macros.svh"

	localparam int DW = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int MW = SAMPLE_BITS + 31;

	skrc_pkg::state_t state_q, state_d;

	logic signed [15:0] thr_q;
	logic [12:0] ratio_q, knee_q;
	logic [16:0] attack_q, release_q;
	logic signed [23:0] env_q;

	logic signed [SAMPLE_BITS-1:0] s_q;
	logic [SAMPLE_BITS-1:0] a_q;
	logic [30:0] z_q;
	logic [4:0] sc_q;
	logic [15:0] frac_q;
	logic [4:0] cnt_q;
	logic signed [15:0] level_q;
	logic [31:0] num_q;
	logic [14:0] rem_q;
	logic [13:0] den_q;
	logic signed [15:0] n_q;
	logic [15:0] f_q;
	logic [30:0] m_q;
	logic [MW-1:0] mag_q;
	logic [SAMPLE_BITS-1:0] out_q;
	logic clip_q;
	logic out_valid_q;

	logic [31:0] root_tab [16];
	for (genvar g = 0; g < 16; g++) begin : g_root
		localparam logic [31:0] ROOT = skrc_pkg::exp_root(g + 1);
		assign root_tab[g] = ROOT;
	end

	logic in_acc;
	logic signed [SAMPLE_BITS-1:0] in_s;
	logic [SAMPLE_BITS-1:0] in_a;
	logic [32:0] mul_x, mul_y;
	logic [65:0] mul_p;
	logic [31:0] zz;
	logic [21:0] lmag;
	logic [16:0] lq;
	logic signed [15:0] level_c;
	logic signed [17:0] diff;
	logic [16:0] dmag;
	logic [13:0] kn, rdiv;
	logic big;
	logic [15:0] dt;
	logic signed [34:0] change;
	logic [32:0] cmag;
	logic [33:0] step;
	logic signed [35:0] env_w;
	logic signed [23:0] env_c;
	logic signed [24:0] gd;
	logic [24:0] gmag;
	logic signed [47:0] gprod;
	logic signed [16:0] sh;
	logic [63:0] mw, lim, mg;
	logic clip_c;
	logic [SAMPLE_BITS-1:0] res_c;
	logic out_free;

	assign in_s = $signed(s_axis_tdata[SAMPLE_BITS-1:0]);
	assign in_a = in_s[SAMPLE_BITS-1] ? SAMPLE_BITS'(-in_s) : SAMPLE_BITS'(in_s);
	assign s_axis_tready = (state_q == skrc_pkg::ST_IDLE);
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;

	assign mul_p = mul_x * mul_y;
	assign zz = mul_p[61:30];
	assign kn = (knee_q == '0) ? 14'd1 : {1'b0, knee_q};
	assign rdiv = (ratio_q == '0) ? 14'd1 : {1'b0, ratio_q};
	assign diff = 18'(level_q) - 18'(thr_q);
	assign dmag = diff[17] ? 17'(-diff) : 17'(diff);
	assign big = diff > $signed({4'b0, kn});
	assign dt = {rem_q, num_q[31]};
	assign lmag = 22'({sc_q, 16'b0}) - 22'((31 - SAMPLE_BITS) * 65536) - 22'(frac_q);
	assign change = 35'(level_q) - $signed({3'b0, num_q}) - 35'(env_q);
	assign cmag = change[34] ? 33'(-change) : 33'(change);
	assign step = mul_p[49:16];
	assign gd = 25'(env_q) - 25'(level_q);
	assign gmag = gd[24] ? 25'(-gd) : 25'(gd);
	assign gprod = gd[24] ? -$signed({1'b0, mul_p[46:0]}) : $signed({1'b0, mul_p[46:0]});
	assign sh = 17'sd30 - 17'(n_q);
	assign mw = 64'(mag_q);
	assign lim = (64'd1 << (SAMPLE_BITS - 1)) - (s_q[SAMPLE_BITS-1] ? 64'd0 : 64'd1);

	always_comb begin
		lq = 17'((mul_p[39:0] + 40'd8388608) >> 24);
		level_c = (lq > 17'd25600) ? skrc_pkg::LEVEL_FLOOR : -$signed(16'(lq));
		env_w = change[34] ? 36'(env_q) - $signed({2'b0, step}) : 36'(env_q) + $signed({2'b0, step});
		if (env_w > 36'sd8388607)
			env_c = 24'sd8388607;
		else if (env_w < -36'sd8388608)
			env_c = -24'sd8388608;
		else
			env_c = env_w[23:0];
		mg = mw;
		if (sh >= 17'sd63) begin
			mg = '0;
		end else if (sh >= 17'sd1) begin
			mg = (mw + (64'd1 << (sh[5:0] - 6'd1))) >> sh[5:0];
		end else if (mw != '0) begin
			if (-sh > 17'sd8 || (mw << 6'(-sh)) > lim)
				mg = lim + 64'd1;
			else
				mg = mw << 6'(-sh);
		end
		clip_c = mg > lim;
		if (clip_c)
			mg = lim;
		res_c = s_q[SAMPLE_BITS-1] ? SAMPLE_BITS'(-mg) : SAMPLE_BITS'(mg);
	end

	always_comb begin
		state_d = state_q;
		mul_x = '0;
		mul_y = '0;
		case (state_q)
			skrc_pkg::ST_IDLE: begin
				if (in_acc)
					state_d = (in_a == '0) ? skrc_pkg::ST_PREP : skrc_pkg::ST_NORM;
			end
			skrc_pkg::ST_NORM: begin
				if (z_q[30])
					state_d = skrc_pkg::ST_LOG;
			end
			skrc_pkg::ST_LOG: begin
				mul_x = 33'(z_q);
				mul_y = 33'(z_q);
				if (cnt_q == 5'd15)
					state_d = skrc_pkg::ST_LEVEL;
			end
			skrc_pkg::ST_LEVEL: begin
				mul_x = 33'(lmag);
				mul_y = 33'(skrc_pkg::DB_PER_OCT_Q16);
				state_d = skrc_pkg::ST_PREP;
			end
			skrc_pkg::ST_PREP: begin
				mul_x = 33'(dmag);
				mul_y = 33'(dmag);
				state_d = skrc_pkg::ST_DIV;
			end
			skrc_pkg::ST_DIV: begin
				if (cnt_q == 5'd31)
					state_d = skrc_pkg::ST_ENV;
			end
			skrc_pkg::ST_ENV: begin
				mul_x = cmag;
				mul_y = 33'(change > 35'sd0 ? attack_q : release_q);
				state_d = skrc_pkg::ST_GAIN;
			end
			skrc_pkg::ST_GAIN: begin
				mul_x = 33'(gmag);
				mul_y = 33'(skrc_pkg::LOG2_10_OVER_20_Q24);
				state_d = skrc_pkg::ST_EXP;
			end
			skrc_pkg::ST_EXP: begin
				mul_x = 33'(m_q);
				mul_y = 33'(root_tab[cnt_q[3:0]]);
				if (cnt_q == 5'd15)
					state_d = skrc_pkg::ST_MAG;
			end
			skrc_pkg::ST_MAG: begin
				mul_x = 33'(a_q);
				mul_y = 33'(m_q);
				state_d = skrc_pkg::ST_OUT;
			end
			skrc_pkg::ST_OUT: begin
				if (out_free)
					state_d = skrc_pkg::ST_IDLE;
			end
			default: state_d = skrc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= skrc_pkg::ST_IDLE;
			thr_q <= skrc_pkg::THRESHOLD_RST;
			ratio_q <= skrc_pkg::RATIO_RST;
			attack_q <= skrc_pkg::ATTACK_RST;
			release_q <= skrc_pkg::RELEASE_RST;
			knee_q <= skrc_pkg::KNEE_RST;
			env_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_addr)
					skrc_pkg::REG_THRESHOLD: thr_q <= $signed(cfg_wdata[15:0]);
					skrc_pkg::REG_RATIO:     ratio_q <= cfg_wdata[12:0];
					skrc_pkg::REG_ATTACK:    attack_q <= cfg_wdata;
					skrc_pkg::REG_RELEASE:   release_q <= cfg_wdata;
					skrc_pkg::REG_KNEE:      knee_q <= cfg_wdata[12:0];
					default: ;
				endcase
			end
			if (state_q == skrc_pkg::ST_ENV)
				env_q <= env_c;
			if (state_q == skrc_pkg::ST_OUT && out_free)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			skrc_pkg::ST_IDLE: begin
				s_q <= in_s;
				a_q <= in_a;
				z_q <= 31'(in_a);
				sc_q <= '0;
				frac_q <= '0;
				cnt_q <= '0;
				level_q <= skrc_pkg::LEVEL_FLOOR;
			end
			skrc_pkg::ST_NORM: begin
				if (!z_q[30]) begin
					z_q <= {z_q[29:0], 1'b0};
					sc_q <= sc_q + 5'd1;
				end
			end
			skrc_pkg::ST_LOG: begin
				if (zz[31]) begin
					z_q <= zz[31:1];
					frac_q[4'd15 - cnt_q[3:0]] <= 1'b1;
				end else begin
					z_q <= zz[30:0];
				end
				cnt_q <= (cnt_q == 5'd15) ? 5'd0 : cnt_q + 5'd1;
			end
			skrc_pkg::ST_LEVEL: level_q <= level_c;
			skrc_pkg::ST_PREP: begin
				num_q <= big ? {6'b0, dmag[15:0], 10'b0} >> 2 : mul_p[31:0];
				den_q <= big ? rdiv : {kn[12:0], 1'b0};
				rem_q <= '0;
				cnt_q <= '0;
			end
			skrc_pkg::ST_DIV: begin
				if (dt >= 16'(den_q)) begin
					rem_q <= 15'(dt - 16'(den_q));
					num_q <= {num_q[30:0], 1'b1};
				end else begin
					rem_q <= dt[14:0];
					num_q <= {num_q[30:0], 1'b0};
				end
				cnt_q <= cnt_q + 5'd1;
			end
			skrc_pkg::ST_GAIN: begin
				n_q <= gprod[47:32];
				f_q <= gprod[31:16];
				m_q <= 31'd1 << 30;
				cnt_q <= '0;
			end
			skrc_pkg::ST_EXP: begin
				if (f_q[4'd15 - cnt_q[3:0]])
					m_q <= mul_p[60:30];
				cnt_q <= cnt_q + 5'd1;
			end
			skrc_pkg::ST_MAG: mag_q <= mul_p[MW-1:0];
			skrc_pkg::ST_OUT: begin
				if (out_free) begin
					out_q <= res_c;
					clip_q <= clip_c;
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = DW'(out_q);
	assign m_axis_tuser = clip_q;

	`SKRC_ASSERT_NXT(a_busy_after_accept, in_acc, !s_axis_tready)
	`SKRC_ASSERT_IMP(a_clip_at_limit, m_axis_tvalid && m_axis_tuser,
		out_q == {1'b0, {(SAMPLE_BITS-1){1'b1}}} || out_q == {1'b1, {(SAMPLE_BITS-1){1'b0}}})
	`SKRC_ASSERT_IMP(a_result_from_out, $rose(m_axis_tvalid), $past(state_q) == skrc_pkg::ST_OUT)

endmodule
